// ----- sv/vcd_pkg.sv -----
// ============================================================================
// vcd_pkg: shared types, command codes and decode helpers
// Command codes, masks and the result word layout used by every stage of
// the music-log command decoder.
// ============================================================================
`default_nettype none

package vcd_pkg;

    // Command codes
    localparam logic [7:0] C_CODE_PSG       = 8'h50;
    localparam logic [7:0] C_CODE_FM0       = 8'h52;
    localparam logic [7:0] C_CODE_FM1       = 8'h53;
    localparam logic [7:0] C_CODE_LONG      = 8'h61;
    localparam logic [7:0] C_CODE_WAIT60    = 8'h62;
    localparam logic [7:0] C_CODE_WAIT50    = 8'h63;
    localparam logic [7:0] C_CODE_SHORT_LO  = 8'h70;
    localparam logic [7:0] C_CODE_SHORT_HI  = 8'h7F;
    localparam logic [7:0] C_CODE_DAC_LO    = 8'h80;
    localparam logic [7:0] C_CODE_DAC_HI    = 8'h8F;
    localparam logic [7:0] C_SHORT_BASE     = 8'h6F;

    // Register addresses and masks
    localparam logic [7:0] C_ADDR_DAC       = 8'h2A;
    localparam logic [7:0] C_ADDR_TIMERA_HI = 8'h24;
    localparam logic [7:0] C_ADDR_TIMERA_LO = 8'h25;
    localparam logic [7:0] C_MASK_FM_FREQ   = 8'hF4;
    localparam logic [7:0] C_FM_FREQ_HI     = 8'hA4;
    localparam logic [7:0] C_FM_FREQ_LO     = 8'hA0;
    localparam logic [7:0] C_MASK_FM_LOADDR = 8'hFB;
    localparam logic [7:0] C_PSG_LIMIT      = 8'hE0;

    // Configuration register indexes and reset values
    localparam logic [7:0]  C_REG_WAIT60   = 8'd0;
    localparam logic [7:0]  C_REG_WAIT50   = 8'd1;
    localparam logic [15:0] C_WAIT60_RESET = 16'd735;
    localparam logic [15:0] C_WAIT50_RESET = 16'd882;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] addr;
        logic [7:0] data;
        logic [7:0] data2;
    } t_item;

    typedef struct packed {
        logic       is_psg;
        logic       is_fm;
        logic       is_fm0;
        logic       is_dac;
        logic       is_dac_zero;
        logic       is_short;
        logic       is_long;
        logic       is_wait60;
        logic       is_wait50;
        logic [3:0] operand_count;
    } t_class;

    typedef struct packed {
        logic [3:0]  operand_count;
        logic [15:0] wait_samples;
        logic        is_chip_write;
        logic        starts_pair;
        logic        ends_pair;
        logic        is_split;
        logic [7:0]  part1_code;
        logic [7:0]  part1_addr;
        logic [7:0]  part2_code;
        logic [7:0]  part2_addr;
        logic [7:0]  part2_data;
    } t_result;

    // Operand byte count that follows a command code
    function automatic logic [3:0] f_operand_len(input logic [7:0] c);
        logic [3:0] len;
        len = 4'd0;
        priority if (c[7:1] == C_CODE_FM0[7:1])           len = 4'd2;
        else if (c == C_CODE_PSG)                         len = 4'd1;
        else if (c >= C_CODE_SHORT_LO && c <= C_CODE_DAC_HI) len = 4'd0;
        else if (c == C_CODE_LONG)                        len = 4'd2;
        else if (c == 8'h64)                              len = 4'd3;
        else if (c >= 8'h62 && c <= 8'h66)                len = 4'd0;
        else if (c == 8'h67)                              len = 4'd6;
        else if (c == 8'hE0)                              len = 4'd4;
        else if (c == 8'h90 || c == 8'h91)                len = 4'd4;
        else if (c == 8'h92)                              len = 4'd5;
        else if (c == 8'h93)                              len = 4'd10;
        else if (c == 8'h94)                              len = 4'd1;
        else if (c == 8'h95)                              len = 4'd4;
        else if (c == 8'h68)                              len = 4'd11;
        else if (c >= 8'h30 && c <= 8'h3F)                len = 4'd1;
        else if ((c >= 8'h40 && c <= 8'h4E) || (c >= 8'hA0 && c <= 8'hBF)) len = 4'd2;
        else if (c >= 8'hC0 && c <= 8'hDF)                len = 4'd3;
        else if (c >= 8'hE1)                              len = 4'd4;
        else                                              len = 4'd0;
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- sv/vcd_classify.sv -----
// ============================================================================
// vcd_classify: first pipeline stage
// Registers the command word and sorts its code into command classes,
// including the operand byte count.
// ============================================================================
`default_nettype none

module vcd_classify
    import vcd_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_valid,
    output logic   o_ready,
    input  t_item  i_item,
    output logic   o_valid,
    input  wire    i_ready,
    output t_item  o_item,
    output t_class o_class
);

    logic   r_valid;
    t_item  r_item;
    t_class r_class;
    t_class n_class;
    logic   w_load;

    // Advance when this stage is empty or its word moves on
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // Sort the code into classes
    always_comb begin
        n_class.is_psg        = (i_item.code == C_CODE_PSG);
        n_class.is_fm         = (i_item.code[7:1] == C_CODE_FM0[7:1]);
        n_class.is_fm0        = (i_item.code == C_CODE_FM0);
        n_class.is_dac        = (i_item.code >= C_CODE_DAC_LO) &&
                                (i_item.code <= C_CODE_DAC_HI);
        n_class.is_dac_zero   = (i_item.code == C_CODE_DAC_LO);
        n_class.is_short      = (i_item.code >= C_CODE_SHORT_LO) &&
                                (i_item.code <= C_CODE_SHORT_HI);
        n_class.is_long       = (i_item.code == C_CODE_LONG);
        n_class.is_wait60     = (i_item.code == C_CODE_WAIT60);
        n_class.is_wait50     = (i_item.code == C_CODE_WAIT50);
        n_class.operand_count = f_operand_len(i_item.code);
    end

    // Hold valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item  <= i_item;
            r_class <= n_class;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_class = r_class;

endmodule

`default_nettype wire

// ----- sv/vcd_resolve.sv -----
// ============================================================================
// vcd_resolve: second pipeline stage
// Works out the wait length, chip-write and pair flags and the split of a
// paired or DAC-with-wait command into two parts.
// ============================================================================
`default_nettype none

module vcd_resolve
    import vcd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [15:0] i_wait60,
    input  wire  [15:0] i_wait50,
    input  wire         i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    input  t_class      i_class,
    output logic        o_valid,
    input  wire         i_ready,
    output t_result     o_result
);

    logic    r_valid;
    t_result r_result;
    t_result n_result;
    logic    w_load;
    logic    w_psg_start;
    logic    w_fm_freq_hi;
    logic    w_fm_freq_lo;
    logic    w_timer_hi;
    logic    w_timer_lo;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // Pair detection terms
    assign w_psg_start  = i_item.data[7] && !i_item.data[4] && (i_item.data < C_PSG_LIMIT);
    assign w_fm_freq_hi = (i_item.addr & C_MASK_FM_FREQ) == C_FM_FREQ_HI;
    assign w_fm_freq_lo = (i_item.addr & C_MASK_FM_FREQ) == C_FM_FREQ_LO;
    assign w_timer_hi   = i_class.is_fm0 && (i_item.addr == C_ADDR_TIMERA_HI);
    assign w_timer_lo   = i_class.is_fm0 && (i_item.addr == C_ADDR_TIMERA_LO);

    // Build the result word
    always_comb begin
        n_result.operand_count = i_class.operand_count;
        n_result.is_chip_write = i_class.is_psg || i_class.is_fm || i_class.is_dac;
        n_result.starts_pair   = 1'b0;
        n_result.ends_pair     = 1'b0;
        n_result.is_split      = 1'b0;
        n_result.part1_code    = i_item.code;
        n_result.part1_addr    = i_item.addr;
        n_result.part2_code    = i_item.code;
        n_result.part2_addr    = i_item.addr;
        n_result.part2_data    = i_item.data2;

        // Wait length
        priority if (i_class.is_dac) begin
            n_result.wait_samples = {12'd0, i_item.code[3:0]};
        end else if (i_class.is_short) begin
            n_result.wait_samples = {11'd0, {1'b0, i_item.code[3:0]} + 5'd1};
        end else if (i_class.is_long) begin
            n_result.wait_samples = {i_item.data2, i_item.data};
        end else if (i_class.is_wait60) begin
            n_result.wait_samples = i_wait60;
        end else if (i_class.is_wait50) begin
            n_result.wait_samples = i_wait50;
        end else begin
            n_result.wait_samples = 16'd0;
        end

        // Pairs and splits
        priority if (i_class.is_psg) begin
            n_result.starts_pair = w_psg_start;
            n_result.is_split    = w_psg_start;
            n_result.ends_pair   = !i_item.data[7];
        end else if (i_class.is_fm) begin
            if (w_fm_freq_hi) begin
                n_result.starts_pair = 1'b1;
                n_result.is_split    = 1'b1;
                n_result.part2_addr  = i_item.addr & C_MASK_FM_LOADDR;
            end else if (w_timer_hi) begin
                n_result.starts_pair = 1'b1;
                n_result.is_split    = 1'b1;
                n_result.part2_addr  = C_ADDR_TIMERA_LO;
            end
            n_result.ends_pair = w_fm_freq_lo || w_timer_lo;
        end else if (i_class.is_dac) begin
            n_result.part1_code = C_CODE_FM0;
            n_result.part1_addr = C_ADDR_DAC;
            if (!i_class.is_dac_zero) begin
                n_result.part2_code = C_SHORT_BASE + {4'd0, i_item.code[3:0]};
                n_result.is_split   = 1'b1;
            end
        end else begin
            n_result.is_split = 1'b0;
        end
    end

    // Hold valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture result
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- sv/vcd_out_stage.sv -----
// ============================================================================
// vcd_out_stage: output register stage
// Holds the finished result word for the consumer; its ready follows the
// consumer's ready directly, so a waiting word stalls the stages behind it.
// ============================================================================
`default_nettype none

module vcd_out_stage
    import vcd_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  wire     i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;

    // Hold valid bit until the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture result word
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- sv/vgm_command_decoder_unit.sv -----
// A word accepted at the input passes the classify, resolve and output registers in order.
// Throughput: one word per cycle while the output is not stalled, set by the three-stage register pipeline.
// A stalled output backs the pipeline up stage by stage without losing a word.
// Reset (synchronous, active low) clears all valid bits and restores the
// frame wait registers to 735 and 882 samples.
// ============================================================================
// vgm_command_decoder_unit: music-log command decoder
// Decodes one command word per cycle, unless the output stalls, into operand count, wait length,
// chip-write and pair flags, and the two-part split of the command.
// ============================================================================
`default_nettype none

module vgm_command_decoder_unit
    import vcd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    // command channel
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_command_code,
    input  wire  [7:0]  i_register_addr,
    input  wire  [7:0]  i_data_byte,
    input  wire  [7:0]  i_data_byte2,
    // result channel
    output logic        o_valid,
    input  wire         i_ready,
    output logic [3:0]  o_operand_count,
    output logic [15:0] o_wait_samples,
    output logic        o_is_chip_write,
    output logic        o_starts_pair,
    output logic        o_ends_pair,
    output logic        o_is_split,
    output logic [7:0]  o_part1_code,
    output logic [7:0]  o_part1_addr,
    output logic [7:0]  o_part2_code,
    output logic [7:0]  o_part2_addr,
    output logic [7:0]  o_part2_data
);

    logic [15:0] r_wait60;
    logic [15:0] r_wait50;
    t_item       w_in_item;
    t_item       w_s1_item;
    t_class      w_s1_class;
    logic        w_s1_valid;
    logic        w_s2_ready;
    logic        w_s2_valid;
    logic        w_s3_ready;
    t_result     w_s2_result;
    t_result     w_out;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait60 <= C_WAIT60_RESET;
            r_wait50 <= C_WAIT50_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == C_REG_WAIT60) begin
                r_wait60 <= i_cfg_data;
            end else if (i_cfg_idx == C_REG_WAIT50) begin
                r_wait50 <= i_cfg_data;
            end
        end
    end

    assign w_in_item.code  = i_command_code;
    assign w_in_item.addr  = i_register_addr;
    assign w_in_item.data  = i_data_byte;
    assign w_in_item.data2 = i_data_byte2;

    vcd_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (w_in_item),
        .o_valid (w_s1_valid),
        .i_ready (w_s2_ready),
        .o_item  (w_s1_item),
        .o_class (w_s1_class)
    );

    vcd_resolve u_resolve (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wait60 (r_wait60),
        .i_wait50 (r_wait50),
        .i_valid  (w_s1_valid),
        .o_ready  (w_s2_ready),
        .i_item   (w_s1_item),
        .i_class  (w_s1_class),
        .o_valid  (w_s2_valid),
        .i_ready  (w_s3_ready),
        .o_result (w_s2_result)
    );

    vcd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_s2_valid),
        .o_ready  (w_s3_ready),
        .i_result (w_s2_result),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_out)
    );

    assign o_operand_count = w_out.operand_count;
    assign o_wait_samples  = w_out.wait_samples;
    assign o_is_chip_write = w_out.is_chip_write;
    assign o_starts_pair   = w_out.starts_pair;
    assign o_ends_pair     = w_out.ends_pair;
    assign o_is_split      = w_out.is_split;
    assign o_part1_code    = w_out.part1_code;
    assign o_part1_addr    = w_out.part1_addr;
    assign o_part2_code    = w_out.part2_code;
    assign o_part2_addr    = w_out.part2_addr;
    assign o_part2_data    = w_out.part2_data;

endmodule

`default_nettype wire

// ----- sv/vcd_checker.sv -----
// ============================================================================
// vcd_checker: port-level checks for the command decoder
// Watches the top-level ports and flags broken handshakes or result words
// whose flags contradict each other.
// ============================================================================
`default_nettype none

module vcd_checker
    import vcd_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_ready,
    input wire [3:0]  o_operand_count,
    input wire [15:0] o_wait_samples,
    input wire        o_is_chip_write,
    input wire        o_starts_pair,
    input wire        o_ends_pair,
    input wire        o_is_split,
    input wire [7:0]  o_part1_code,
    input wire [7:0]  o_part1_addr,
    input wire [7:0]  o_part2_code,
    input wire [7:0]  o_part2_addr,
    input wire [7:0]  o_part2_data
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_wait_samples) &&
        $stable(o_part1_code) && $stable(o_part2_code) && $stable(o_part2_data) &&
        $stable(o_part2_addr))
        else $error("result word changed while stalled");

    // Nothing leaves the pipeline right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid directly after reset");

    // Pair and split flags only on chip writes
    a_flags_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_chip_write |-> !o_starts_pair && !o_ends_pair && !o_is_split)
        else $error("pair or split flag on a non-write command");

    // A write without operands is a DAC write, remapped to the DAC register
    a_dac_remap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_chip_write && (o_operand_count == 4'd0) |->
        (o_part1_code == C_CODE_FM0) && (o_part1_addr == C_ADDR_DAC) &&
        !o_starts_pair && !o_ends_pair)
        else $error("DAC write not remapped");

endmodule

bind vgm_command_decoder_unit vcd_checker u_vcd_checker (.*);

`default_nettype wire
